>>> hdl/fpdf_pkg.sv
// Shared types and constants for the fixed-point decimal formatter.
`default_nettype none
package fpdf_pkg;

    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 8;
    localparam int VALUE_W             = 32;
    localparam int CHAR_W              = 8;
    localparam int CFG_W               = 4;
    localparam int MUL_W               = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = 4'd3;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

    // Exact reciprocal of ten for any 32-bit operand: q = (x * RECIP_10) >> RECIP_SHIFT.
    localparam logic [MUL_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam logic [MUL_W-1:0] TEN         = 32'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FRAC
    } t_state;

    typedef enum logic {
        MUL_RECIP,
        MUL_TEN
    } t_mul_op;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

endpackage
`default_nettype wire

>>> hdl/fpdf_mul.sv
// Shared constant multiplier: divide-by-ten reciprocal or times-ten, registered product.
`default_nettype none
module fpdf_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire fpdf_pkg::t_mul_op           i_op,
    input  wire logic [fpdf_pkg::MUL_W-1:0]  i_a,
    output logic      [2*fpdf_pkg::MUL_W-1:0] o_prod
);

    logic [fpdf_pkg::MUL_W-1:0]   w_b;
    logic [2*fpdf_pkg::MUL_W-1:0] r_prod;

    always_comb begin
        case (i_op)
            fpdf_pkg::MUL_RECIP: w_b = fpdf_pkg::RECIP_10;
            fpdf_pkg::MUL_TEN:   w_b = fpdf_pkg::TEN;
            default:             w_b = fpdf_pkg::TEN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * w_b;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> hdl/fpdf_seq.sv
// Sequencer: splits the value, extracts integer digits and fraction digits, emits characters.
`default_nettype none
module fpdf_seq #(
    parameter int FRAC_BITS       = fpdf_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = fpdf_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [fpdf_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [fpdf_pkg::CFG_W-1:0]    i_frac_digits,
    output logic                               o_busy,
    input  wire logic                          i_emit_ok,
    output fpdf_pkg::t_char                    o_char
);

    localparam int INT_W      = fpdf_pkg::VALUE_W - 1 - FRAC_BITS;
    // Decimal digits of the largest integer part (log10(2) is about 1233/4096).
    localparam int INT_DIGITS = ((INT_W * 1233) >> 12) + 1;
    localparam int IDX_W      = $clog2(INT_DIGITS);
    localparam int CNT_W      = $clog2(INT_DIGITS + 1);
    localparam int ND_W       = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int PROD_W     = 2 * fpdf_pkg::MUL_W;

    fpdf_pkg::t_state  r_state, n_state;
    fpdf_pkg::t_mul_op w_op;
    logic                        w_mul_en;
    logic [fpdf_pkg::MUL_W-1:0]  w_mul_a;
    logic [PROD_W-1:0]           w_prod;

    logic                  r_neg;
    logic [INT_W-1:0]      r_x;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [ND_W-1:0]       r_nd;
    logic [ND_W-1:0]       r_k;
    logic [CNT_W-1:0]      r_cnt;
    logic [3:0]            r_digits [INT_DIGITS];

    logic                         w_accept;
    logic [fpdf_pkg::VALUE_W-1:0] w_mag;
    logic [INT_W-1:0]             w_q;
    logic [3:0]                   w_q4;
    logic [3:0]                   w_ten_q;
    logic [3:0]                   w_rem;
    logic [CNT_W-1:0]             w_rd_cnt;
    logic [3:0]                   w_frac_digit;
    logic                         w_frac_last;
    logic [ND_W-1:0]              w_nd;

    fpdf_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_op   (w_op),
        .i_a    (w_mul_a),
        .o_prod (w_prod)
    );

    assign w_accept = (r_state == fpdf_pkg::ST_IDLE) && i_in_valid;
    assign o_busy   = (r_state != fpdf_pkg::ST_IDLE);

    // Magnitude; the most negative value saturates to the largest positive one.
    always_comb begin
        if (!i_value[fpdf_pkg::VALUE_W-1]) begin
            w_mag = i_value;
        end else if (i_value[fpdf_pkg::VALUE_W-2:0] == '0) begin
            w_mag = {1'b0, {(fpdf_pkg::VALUE_W-1){1'b1}}};
        end else begin
            w_mag = ~i_value + 1'b1;
        end
    end

    assign w_nd = (i_frac_digits > fpdf_pkg::CFG_W'(MAX_FRAC_DIGITS))
                ? ND_W'(MAX_FRAC_DIGITS) : ND_W'(i_frac_digits);

    // Quotient from the reciprocal product; the remainder only needs four bits
    // because it is known to be below ten.
    assign w_q      = w_prod[fpdf_pkg::RECIP_SHIFT +: INT_W];
    assign w_q4     = w_q[3:0];
    assign w_ten_q  = {w_q4[0], 3'b000} + {w_q4[2:0], 1'b0};
    assign w_rem    = r_x[3:0] - w_ten_q;
    assign w_rd_cnt = r_cnt - 1'b1;

    assign w_frac_digit = w_prod[FRAC_BITS +: 4];
    assign w_frac_last  = (ND_W'(r_k + 1'b1) == r_nd);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpdf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fpdf_pkg::ST_DIV;
                end
            end
            fpdf_pkg::ST_DIV: begin
                n_state = fpdf_pkg::ST_DIGIT;
            end
            fpdf_pkg::ST_DIGIT: begin
                if (w_q != '0) begin
                    n_state = fpdf_pkg::ST_DIV;
                end else if (r_neg) begin
                    n_state = fpdf_pkg::ST_SIGN;
                end else begin
                    n_state = fpdf_pkg::ST_INT;
                end
            end
            fpdf_pkg::ST_SIGN: begin
                if (i_emit_ok) begin
                    n_state = fpdf_pkg::ST_INT;
                end
            end
            fpdf_pkg::ST_INT: begin
                if (i_emit_ok && r_cnt == CNT_W'(1)) begin
                    n_state = fpdf_pkg::ST_DOT;
                end
            end
            fpdf_pkg::ST_DOT: begin
                if (i_emit_ok) begin
                    n_state = (r_nd == '0) ? fpdf_pkg::ST_IDLE : fpdf_pkg::ST_FRAC;
                end
            end
            fpdf_pkg::ST_FRAC: begin
                if (i_emit_ok && w_frac_last) begin
                    n_state = fpdf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpdf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: emitted character and multiplier control.
    always_comb begin
        o_char   = '0;
        w_mul_en = 1'b0;
        w_op     = fpdf_pkg::MUL_TEN;
        w_mul_a  = fpdf_pkg::MUL_W'(r_frac);
        case (r_state)
            fpdf_pkg::ST_IDLE: begin
                o_char = '0;
            end
            fpdf_pkg::ST_DIV: begin
                w_mul_en = 1'b1;
                w_op     = fpdf_pkg::MUL_RECIP;
                w_mul_a  = fpdf_pkg::MUL_W'(r_x);
            end
            fpdf_pkg::ST_DIGIT: begin
                w_mul_en = 1'b0;
            end
            fpdf_pkg::ST_SIGN: begin
                o_char.valid = 1'b1;
                o_char.code  = fpdf_pkg::CH_MINUS;
            end
            fpdf_pkg::ST_INT: begin
                o_char.valid = 1'b1;
                o_char.code  = fpdf_pkg::CH_ZERO
                             + fpdf_pkg::CHAR_W'(r_digits[w_rd_cnt[IDX_W-1:0]]);
            end
            fpdf_pkg::ST_DOT: begin
                // The first times-ten product is formed while the point goes out.
                o_char.valid = 1'b1;
                o_char.code  = fpdf_pkg::CH_DOT;
                o_char.last  = (r_nd == '0);
                w_mul_en     = 1'b1;
            end
            fpdf_pkg::ST_FRAC: begin
                o_char.valid = 1'b1;
                o_char.code  = fpdf_pkg::CH_ZERO + fpdf_pkg::CHAR_W'(w_frac_digit);
                o_char.last  = w_frac_last;
                w_mul_en     = i_emit_ok;
                w_mul_a      = fpdf_pkg::MUL_W'(w_prod[FRAC_BITS-1:0]);
            end
            default: begin
                o_char = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpdf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_k   <= '0;
        end else if (w_accept) begin
            r_cnt <= '0;
            r_k   <= '0;
        end else if (r_state == fpdf_pkg::ST_DIGIT) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (r_state == fpdf_pkg::ST_INT && i_emit_ok) begin
            r_cnt <= w_rd_cnt;
        end else if (r_state == fpdf_pkg::ST_FRAC && i_emit_ok) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg  <= i_value[fpdf_pkg::VALUE_W-1];
            r_x    <= w_mag[FRAC_BITS +: INT_W];
            r_frac <= w_mag[FRAC_BITS-1:0];
            r_nd   <= w_nd;
        end else if (r_state == fpdf_pkg::ST_DIGIT) begin
            r_x                       <= w_q;
            r_digits[r_cnt[IDX_W-1:0]] <= w_rem;
        end
    end

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpdf_pkg::ST_IDLE) |-> !o_char.valid)
        else $error("character emitted while idle");

    a_rem_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpdf_pkg::ST_DIGIT) |-> (w_rem < 4'd10 && r_cnt < CNT_W'(INT_DIGITS)))
        else $error("integer digit out of range or digit store overflow");

    a_int_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpdf_pkg::ST_INT) |-> (r_cnt != '0))
        else $error("integer emission with empty digit store");

    a_frac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpdf_pkg::ST_FRAC) |-> (r_k < r_nd && w_frac_digit < 4'd10))
        else $error("fraction digit count or value out of range");

    a_dot_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == fpdf_pkg::ST_INT && r_state != fpdf_pkg::ST_INT)
        |-> (r_state == fpdf_pkg::ST_DOT))
        else $error("integer digits not followed by the point");

endmodule
`default_nettype wire

>>> hdl/fixed_point_decimal_formatter_top.sv
// Top level of the fixed-point decimal formatter: configuration register and output register.
`default_nettype none
// Converts one signed fixed-point value (FRAC_BITS fraction bits) into its decimal text, one
// ASCII character per output word, with the final character flagged by o_last_char. The text
// is an optional '-', the integer digits without leading zeros, '.', then frac_digits fraction
// digits (truncated, clamped to MAX_FRAC_DIGITS). One value is converted at a time: after a
// value is taken, o_in_stall stays high until its last character has left the sequencer.
// Integer digits come from one shared constant multiplier that divides by ten; fraction digits
// reuse it as a times-ten unit, one digit per cycle unless the output stalls. The default
// format is Q15.16.
module fixed_point_decimal_formatter_top #(
    parameter int FRAC_BITS       = fpdf_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = fpdf_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [fpdf_pkg::VALUE_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [fpdf_pkg::CHAR_W-1:0]   o_char_code,
    output logic                               o_last_char,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fpdf_pkg::CFG_W-1:0]    i_frac_digits
);

    logic [fpdf_pkg::CFG_W-1:0]  r_frac_digits;
    logic                        r_out_valid;
    logic [fpdf_pkg::CHAR_W-1:0] r_char_code;
    logic                        r_last_char;
    logic                        w_busy;
    logic                        w_emit_ok;
    fpdf_pkg::t_char             w_char;

    // A new word may enter the output register when it is empty or being taken.
    assign w_emit_ok   = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;

    fpdf_seq #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_value       (i_value),
        .i_frac_digits (r_frac_digits),
        .o_busy        (w_busy),
        .i_emit_ok     (w_emit_ok),
        .o_char        (w_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_digits <= fpdf_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frac_digits <= i_frac_digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_ok) begin
            r_out_valid <= w_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_ok && w_char.valid) begin
            r_char_code <= w_char.code;
            r_last_char <= w_char.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char_code;
    assign o_last_char = r_last_char;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_char_code)))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after taking a value");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_ok && w_char.valid && w_char.last) |=> !o_in_stall)
        else $error("sequencer still busy after the last character");

endmodule
`default_nettype wire
